// ----- sv/aging_priority_round_robin_arbiter_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the aging priority round-robin arbiter
// Concurrent checks on clk, disabled while arst_n is low; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef AGING_PRIORITY_ROUND_ROBIN_ARBITER_UNIT_ASSERT_SVH
`define AGING_PRIORITY_ROUND_ROBIN_ARBITER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset.
`define APARB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Implication: when trig holds, expect holds on the next edge.
`define APARB_ASSERT_NEXT(lbl, trig, expect_q, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expect_q)) \
		else $error(msg);
`else
`define APARB_ASSERT(lbl, prop, msg)
`define APARB_ASSERT_NEXT(lbl, trig, expect_q, msg)
`endif

`endif

// ----- sv/aparb_pkg.sv -----
// ---------------------------------------------------------------------------
// aparb_pkg
// Shared constants, codes and types of the aging priority round-robin arbiter.
// ---------------------------------------------------------------------------
package aparb_pkg;

	// defaults of the top-level parameters
	localparam int REQUESTERS_DEF    = 8;
	localparam int AGE_LIMIT_DEF     = 1000;
	localparam int PRIORITY_BITS_DEF = 8;

	// widths sized for the largest legal parameter values
	localparam int IDX_MAX_W   = 4;   // up to 16 requesters
	localparam int CNT_MAX_W   = 5;   // count of up to 16
	localparam int SCORE_MAX_W = 17;  // 16-bit priority plus 16-bit age

	// fixed field widths
	localparam int FUNC_W      = 2;
	localparam int REQ_W       = 3;
	localparam int MASK_W      = 8;
	localparam int ACT_W       = 4;
	localparam int PRIO_VEC_W  = 64;
	localparam int SCORE_OUT_W = 11;
	localparam int COUNT_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [ACT_W-1:0]  ACTIVE_RST = ACT_W'(8);
	localparam logic [MASK_W-1:0] ENABLE_RST = MASK_W'(255);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_REQUEST   = 2'd0,
		FUNC_ARBITRATE = 2'd1,
		FUNC_COMPLETE  = 2'd2
	} func_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE   = 2'd0,
		CFG_ENABLE   = 2'd1,
		CFG_PRIORITY = 2'd2
	} cfg_idx_e;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_REQUEST,
		OP_RECONNECT,
		OP_COMPLETE,
		OP_GRANT
	} cell_op_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_SCAN,
		ST_FINISH
	} state_e;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		cell_op_e             op;
		logic [COUNT_W-1:0]   snap;
	} cell_ctrl_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic                   valid;
		logic                   last;
		logic                   granted;
		logic [SCORE_MAX_W-1:0] score;
		logic [IDX_MAX_W-1:0]   idx;
		logic [CNT_MAX_W-1:0]   remaining;
	} tok_t;

endpackage

// ----- sv/aparb_cell.sv -----
// ---------------------------------------------------------------------------
// aparb_cell
// One requester: request count, wait age, and one stage of the scan ring.
// ---------------------------------------------------------------------------
module aparb_cell #(
	parameter int CELL_IDX      = 0,
	parameter int AGE_LIMIT     = aparb_pkg::AGE_LIMIT_DEF,
	parameter int AGE_W         = 10,
	parameter int PRIORITY_BITS = aparb_pkg::PRIORITY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  aparb_pkg::cell_ctrl_t              ctrl,
	input  logic                               sel,
	input  logic                               enabled,
	input  logic                               nonempty,
	input  logic [PRIORITY_BITS-1:0]           prio,
	input  aparb_pkg::tok_t                    tok_in,
	output aparb_pkg::tok_t                    tok_out,
	output logic [aparb_pkg::COUNT_W-1:0]      count
);
	import aparb_pkg::*;

	logic [COUNT_W-1:0]     count_q;
	logic [AGE_W-1:0]       age_q;
	tok_t                   tok_q;
	tok_t                   tok_nxt;
	logic [SCORE_MAX_W-1:0] score;
	logic                   live;
	logic                   take;
	logic                   drop;

	always_comb begin
		score = SCORE_MAX_W'(prio) + SCORE_MAX_W'(age_q);
		live  = tok_in.valid && (count_q != '0);
		take  = live && enabled && nonempty;
		drop  = live && !(enabled && nonempty);
		tok_nxt = '0;
		if (tok_in.valid) begin
			tok_nxt           = tok_in;
			tok_nxt.remaining = tok_in.remaining - CNT_MAX_W'(1);
			tok_nxt.last      = (tok_in.remaining == CNT_MAX_W'(1));
			// strictly higher score displaces the best so far
			if (take && (!tok_in.granted || (score > tok_in.score))) begin
				tok_nxt.granted = 1'b1;
				tok_nxt.score   = score;
				tok_nxt.idx     = IDX_MAX_W'(CELL_IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			age_q   <= '0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (drop) begin
				count_q <= '0;
			end else begin
				unique case (ctrl.op) inside
					OP_REQUEST, OP_RECONNECT: begin
						if (sel) count_q <= count_q + COUNT_W'(1);
					end
					OP_COMPLETE: begin
						if (sel && (count_q == ctrl.snap)) count_q <= '0;
					end
					default: ;
				endcase
			end
			if (take && (age_q < AGE_W'(AGE_LIMIT))) begin
				age_q <= age_q + AGE_W'(1);
			end else if ((ctrl.op == OP_GRANT) && sel) begin
				age_q <= '0;
			end
		end
	end

	assign tok_out = tok_q;
	assign count   = count_q;

endmodule

// ----- sv/aging_priority_round_robin_arbiter_unit.sv -----
// ---------------------------------------------------------------------------
// aging_priority_round_robin_arbiter_unit
// Aging priority round-robin arbiter built as a ring of requester cells.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive func and its operand fields with start high; the
//   command transfers at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with granted, grant_index,
//   grant_score and any_pending; the receiver cannot stall, so the result
//   must be taken in that cycle.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once;
//   write only while busy is low and no result is outstanding.
// Timing:
//   Request, completion, link-down arbitrate, unused codes: the result is
//   registered after the finish state; a new command may follow as it is taken.
//   Arbitrate with the link up: the start cursor is first reduced modulo the
//   active count (one subtract per cycle), then a token is launched at the
//   cursor and walks the cell ring, one cell per cycle, over all active
//   cells; busy stays high until the walk ends. With no active requester a
//   link-up arbitrate takes the short path above.
// Reset: arst_n clears counts, ages, cursor, link history, snapshot and
//   loads the configuration reset values (8 active, all enabled, priority 0).
// ---------------------------------------------------------------------------
`include "aging_priority_round_robin_arbiter_unit_assert.svh"

module aging_priority_round_robin_arbiter_unit #(
	parameter int REQUESTERS    = aparb_pkg::REQUESTERS_DEF,
	parameter int AGE_LIMIT     = aparb_pkg::AGE_LIMIT_DEF,
	parameter int PRIORITY_BITS = aparb_pkg::PRIORITY_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic [aparb_pkg::FUNC_W-1:0]        func,
	input  logic [aparb_pkg::REQ_W-1:0]         requester,
	input  logic                                link_up,
	input  logic [aparb_pkg::MASK_W-1:0]        nonempty_mask,
	input  logic                                send_ok,
	input  logic                                store_now_empty,
	// result channel
	output logic                                done,
	output logic                                granted,
	output logic [aparb_pkg::REQ_W-1:0]         grant_index,
	output logic [aparb_pkg::SCORE_OUT_W-1:0]   grant_score,
	output logic                                any_pending,
	// configuration port
	input  logic                                cfg_we,
	input  logic [aparb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aparb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import aparb_pkg::*;

	localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
	localparam int CNT_W = $clog2(REQUESTERS + 1);
	localparam int AGE_W = $clog2(AGE_LIMIT + 1);

	// configuration registers
	logic [ACT_W-1:0]      active_q;
	logic [MASK_W-1:0]     enable_q;
	logic [PRIO_VEC_W-1:0] prio_q;

	// sequencer state
	state_e                state_q, state_d;
	logic                  link_was_q;
	logic [IDX_W-1:0]      cursor_q;
	logic [IDX_W-1:0]      start_q;
	logic [COUNT_W-1:0]    snap_q;
	logic [MASK_W-1:0]     ne_q;

	// result registers
	logic                  done_q;
	logic                  granted_q;
	logic [REQ_W-1:0]      gidx_q;
	logic [SCORE_OUT_W-1:0] gscore_q;
	logic                  pend_q;

	// ring
	tok_t                  tok_q   [REQUESTERS];
	tok_t                  cont_tok[REQUESTERS];
	tok_t                  ring_in [REQUESTERS];
	logic [COUNT_W-1:0]    count_arr[REQUESTERS];
	logic [REQUESTERS-1:0] tok_live;
	logic [REQUESTERS-1:0] act_mask;
	logic [REQUESTERS-1:0] req_hit;
	logic [REQUESTERS-1:0] win_hit;
	logic [REQUESTERS-1:0] pend_vec;
	tok_t                  fresh;
	tok_t                  wrap_tok;
	tok_t                  fin;

	// sequencer outputs
	cell_ctrl_t            ctrl;
	logic [REQUESTERS-1:0] sel;
	logic                  inject;
	logic                  result_fire;
	logic                  grant_fire;
	logic                  link_clr;
	logic                  link_set;
	logic                  load_start;
	logic                  start_dec;

	logic [CNT_W-1:0]      cnt;
	logic [CNT_W-1:0]      cursor_inc;
	logic                  any_pend;

	// clamp the active count to the number of cells
	always_comb begin
		if ({1'b0, active_q} > (ACT_W + 1)'(REQUESTERS)) begin
			cnt = CNT_W'(REQUESTERS);
		end else begin
			cnt = CNT_W'(active_q);
		end
	end

	always_comb begin
		fresh           = '0;
		fresh.valid     = 1'b1;
		fresh.remaining = CNT_MAX_W'(cnt);
	end

	assign wrap_tok = cont_tok[IDX_W'(cnt - CNT_W'(1))];

	for (genvar i = 0; i < REQUESTERS; i++) begin : g_cell
		localparam int PLO = i * PRIORITY_BITS;
		logic                     en_i;
		logic                     ne_i;
		logic [PRIORITY_BITS-1:0] prio_i;

		if (i < MASK_W) begin : g_mask
			assign en_i = enable_q[i];
			assign ne_i = ne_q[i];
		end else begin : g_nomask
			assign en_i = 1'b0;
			assign ne_i = 1'b0;
		end

		// requesters past the packed vector read zero priority
		if (PLO >= PRIO_VEC_W) begin : g_prio_none
			assign prio_i = '0;
		end else if (PLO + PRIORITY_BITS <= PRIO_VEC_W) begin : g_prio_full
			assign prio_i = prio_q[PLO +: PRIORITY_BITS];
		end else begin : g_prio_part
			assign prio_i = PRIORITY_BITS'(prio_q[PRIO_VEC_W-1:PLO]);
		end

		assign act_mask[i] = (CNT_W'(i) < cnt);
		assign req_hit[i]  = act_mask[i] && (IDX_MAX_W'(requester) == IDX_MAX_W'(i));
		assign win_hit[i]  = (fin.idx == IDX_MAX_W'(i));
		assign pend_vec[i] = act_mask[i] && (count_arr[i] != '0);
		assign tok_live[i] = tok_q[i].valid;

		// a token that finished its walk stops here
		always_comb begin
			cont_tok[i]       = tok_q[i];
			cont_tok[i].valid = tok_q[i].valid && !tok_q[i].last;
		end

		// hand the token on; the last active cell wraps to cell zero
		if (i == 0) begin : g_head
			always_comb begin
				ring_in[i] = wrap_tok;
				if (inject && (start_q == IDX_W'(i))) ring_in[i] = fresh;
			end
		end else begin : g_body
			always_comb begin
				ring_in[i] = act_mask[i] ? cont_tok[i-1] : '0;
				if (inject && (start_q == IDX_W'(i))) ring_in[i] = fresh;
			end
		end

		aparb_cell #(
			.CELL_IDX      (i),
			.AGE_LIMIT     (AGE_LIMIT),
			.AGE_W         (AGE_W),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sel      (sel[i]),
			.enabled  (en_i),
			.nonempty (ne_i),
			.prio     (prio_i),
			.tok_in   (ring_in[i]),
			.tok_out  (tok_q[i]),
			.count    (count_arr[i])
		);
	end

	// pick up the token that ended its walk this cycle
	always_comb begin
		fin = '0;
		for (int j = 0; j < REQUESTERS; j++) begin
			if (tok_q[j].valid && tok_q[j].last) fin = tok_t'(fin | tok_q[j]);
		end
	end

	assign any_pend   = |pend_vec;
	assign cursor_inc = CNT_W'(fin.idx) + CNT_W'(1);

	// ---------------------------------------------------------------------
	// Sequencer: next state and per-cycle controls
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl.op     = OP_NONE;
		ctrl.snap   = snap_q;
		sel         = '0;
		inject      = 1'b0;
		result_fire = 1'b0;
		grant_fire  = 1'b0;
		link_clr    = 1'b0;
		link_set    = 1'b0;
		load_start  = 1'b0;
		start_dec   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_FINISH;
					unique case (func)
						FUNC_REQUEST: begin
							ctrl.op = OP_REQUEST;
							sel     = req_hit;
						end
						FUNC_COMPLETE: begin
							// match against the snapshot taken at grant time
							ctrl.op = OP_COMPLETE;
							if (send_ok && store_now_empty) sel = req_hit;
						end
						FUNC_ARBITRATE: begin
							if (!link_up) begin
								link_clr = 1'b1;
							end else begin
								// on reconnect, request every active requester first
								if (!link_was_q) begin
									ctrl.op  = OP_RECONNECT;
									sel      = act_mask;
									link_set = 1'b1;
								end
								if (cnt != '0) begin
									load_start = 1'b1;
									state_d    = ST_NORM;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_NORM: begin
				// reduce the cursor below the active count, then launch the token
				if (CNT_W'(start_q) >= cnt) begin
					start_dec = 1'b1;
				end else begin
					inject  = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (fin.valid) begin
					result_fire = 1'b1;
					grant_fire  = fin.granted;
					if (fin.granted) begin
						ctrl.op = OP_GRANT;
						sel     = win_hit;
					end
					state_d = ST_IDLE;
				end
			end
			ST_FINISH: begin
				result_fire = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// ---------------------------------------------------------------------
	// Configuration, link history, cursor, snapshot
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= ACTIVE_RST;
			enable_q   <= ENABLE_RST;
			prio_q     <= '0;
			link_was_q <= 1'b0;
			cursor_q   <= '0;
			start_q    <= '0;
			snap_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ACTIVE:   active_q <= cfg_data[ACT_W-1:0];
					CFG_ENABLE:   enable_q <= cfg_data[MASK_W-1:0];
					CFG_PRIORITY: prio_q   <= cfg_data[PRIO_VEC_W-1:0];
					default: ;
				endcase
			end
			if (link_clr) link_was_q <= 1'b0;
			else if (link_set) link_was_q <= 1'b1;
			if (load_start) begin
				start_q <= cursor_q;
			end else if (start_dec) begin
				start_q <= IDX_W'(CNT_W'(start_q) - cnt);
			end
			if (grant_fire) begin
				// advance the cursor past the winner, wrapping at the active count
				cursor_q <= (cursor_inc == cnt) ? '0 : IDX_W'(cursor_inc);
				snap_q   <= count_arr[IDX_W'(fin.idx)];
			end
			done_q <= result_fire;
		end
	end

	// operand and result payload: no reset
	always_ff @(posedge clk) begin
		if (start && !busy && (func == FUNC_ARBITRATE)) ne_q <= nonempty_mask;
		if (result_fire) begin
			granted_q <= grant_fire;
			gidx_q    <= grant_fire ? REQ_W'(fin.idx) : '0;
			gscore_q  <= grant_fire ? SCORE_OUT_W'(fin.score) : '0;
			pend_q    <= any_pend;
		end
	end

	assign done        = done_q;
	assign granted     = granted_q;
	assign grant_index = gidx_q;
	assign grant_score = gscore_q;
	assign any_pending = pend_q;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	`APARB_ASSERT(a_single_token, $onehot0(tok_live), "more than one scan token in the ring")
	`APARB_ASSERT(a_grant_active, (fin.valid && fin.granted) |-> (CNT_MAX_W'(fin.idx) < CNT_MAX_W'(cnt)), "grant to an inactive requester")
	`APARB_ASSERT(a_token_idle, (state_q == ST_IDLE) |-> (tok_live == '0), "scan token alive while idle")
	`APARB_ASSERT_NEXT(a_strobe_single, done, !done, "result strobe held for more than one cycle")

endmodule

// ----- tb/aparb_grant_checker.sv -----
// ---------------------------------------------------------------------------
// aparb_grant_checker
// Follows the command and configuration traffic of the arbiter, keeps its
// own copy of counts, ages, cursor and snapshot, works out the result of
// every accepted command and compares it with the strobed result.
// ---------------------------------------------------------------------------
module aparb_grant_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [aparb_pkg::FUNC_W-1:0]      func,
	input  logic [aparb_pkg::REQ_W-1:0]       requester,
	input  logic                              link_up,
	input  logic [aparb_pkg::MASK_W-1:0]      nonempty_mask,
	input  logic                              send_ok,
	input  logic                              store_now_empty,
	input  logic                              done,
	input  logic                              granted,
	input  logic [aparb_pkg::REQ_W-1:0]       grant_index,
	input  logic [aparb_pkg::SCORE_OUT_W-1:0] grant_score,
	input  logic                              any_pending,
	input  logic                              cfg_we,
	input  logic [aparb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aparb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              drain_done,
	output int                                fails
);
	import aparb_pkg::*;

	localparam int N_REQ     = REQUESTERS_DEF;
	localparam int AGE_CAP   = AGE_LIMIT_DEF;
	localparam int PBITS     = PRIORITY_BITS_DEF;
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic                   granted;
		logic [REQ_W-1:0]       idx;
		logic [SCORE_OUT_W-1:0] score;
		logic                   any_pending;
	} grant_result_t;

	grant_result_t grant_due[$];

	logic [COUNT_W-1:0]    pend_cnt [N_REQ];
	logic [10:0]           age_ctr  [N_REQ];
	logic [REQ_W-1:0]      scan_ptr;
	logic                  link_prev;
	logic [COUNT_W-1:0]    snap_cnt;
	logic [ACT_W-1:0]      act_reg;
	logic [MASK_W-1:0]     en_reg;
	logic [PRIO_VEC_W-1:0] prio_reg;

	initial fails = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fails < PRINT_CAP)
			$display("[%0t] arbiter mismatch, %s: got %0d, want %0d", $time, what, got, want);
		fails++;
	endtask

	// apply one command to the local state and queue the result it must give
	task automatic predict_grant(input logic [FUNC_W-1:0] f, input logic [REQ_W-1:0] r,
			input logic lk, input logic [MASK_W-1:0] ne, input logic ok, input logic em);
		int unsigned n_act, slot, score, best, i;
		logic won, any;
		logic [REQ_W-1:0] winner;
		grant_result_t res;
		n_act  = (act_reg > N_REQ) ? N_REQ : act_reg;
		won    = 1'b0;
		best   = 0;
		winner = '0;
		case (f)
			FUNC_REQUEST: begin
				if (r < n_act)
					pend_cnt[r] = pend_cnt[r] + 1'b1;
			end
			FUNC_ARBITRATE: begin
				if (!lk) begin
					link_prev = 1'b0;
				end else begin
					// reconnect: every active requester gets one request
					if (!link_prev) begin
						for (i = 0; i < n_act; i++)
							pend_cnt[i] = pend_cnt[i] + 1'b1;
						link_prev = 1'b1;
					end
					for (i = 0; i < n_act; i++) begin
						slot = (scan_ptr + i) % n_act;
						if (pend_cnt[slot] == '0)
							continue;
						if (!en_reg[slot] || !ne[slot]) begin
							pend_cnt[slot] = '0;
							continue;
						end
						score = prio_reg[slot*PBITS +: PBITS] + age_ctr[slot];
						// ties keep the earlier one in rotation
						if (!won || score > best) begin
							won    = 1'b1;
							best   = score;
							winner = REQ_W'(slot);
						end
						if (age_ctr[slot] < AGE_CAP)
							age_ctr[slot] = age_ctr[slot] + 1'b1;
					end
					if (won) begin
						age_ctr[winner] = '0;
						snap_cnt        = pend_cnt[winner];
						scan_ptr        = REQ_W'((winner + 1) % n_act);
					end
				end
			end
			FUNC_COMPLETE: begin
				if (r < n_act && ok && em && pend_cnt[r] == snap_cnt)
					pend_cnt[r] = '0;
			end
			default: ;
		endcase
		any = 1'b0;
		for (i = 0; i < n_act; i++)
			if (pend_cnt[i] != '0)
				any = 1'b1;
		res.granted     = won;
		res.idx         = won ? winner : '0;
		res.score       = won ? SCORE_OUT_W'(best) : '0;
		res.any_pending = any;
		grant_due.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		grant_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < N_REQ; i++) begin
				pend_cnt[i] = '0;
				age_ctr[i]  = '0;
			end
			scan_ptr  = '0;
			link_prev = 1'b0;
			snap_cnt  = '0;
			act_reg   = ACTIVE_RST;
			en_reg    = ENABLE_RST;
			prio_reg  = '0;
			grant_due.delete();
		end else begin
			if (done) begin
				if (grant_due.size() == 0) begin
					report_mismatch("result with no command outstanding", 1, 0);
				end else begin
					want = grant_due.pop_front();
					if (granted !== want.granted)
						report_mismatch("granted", granted, want.granted);
					if (grant_index !== want.idx)
						report_mismatch("grant_index", grant_index, want.idx);
					if (grant_score !== want.score)
						report_mismatch("grant_score", grant_score, want.score);
					if (any_pending !== want.any_pending)
						report_mismatch("any_pending", any_pending, want.any_pending);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACTIVE:   act_reg  = cfg_data[ACT_W-1:0];
					CFG_ENABLE:   en_reg   = cfg_data[MASK_W-1:0];
					CFG_PRIORITY: prio_reg = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				predict_grant(func, requester, link_up, nonempty_mask, send_ok,
					store_now_empty);
		end
	end

	always @(posedge drain_done) begin
		if (grant_due.size() != 0)
			report_mismatch("results still outstanding at end of run", 0, grant_due.size());
	end

endmodule

// ----- tb/tb_aging_priority_round_robin_arbiter_unit.sv -----
// ---------------------------------------------------------------------------
// tb_aging_priority_round_robin_arbiter_unit
// Drives commands and register writes into the aging priority round-robin
// arbiter: a short directed pass over the corner cases, then random episodes
// of requests, arbitration and completion under several register settings
// and sender idle rates. A separate checker predicts and compares results.
// ---------------------------------------------------------------------------
module tb_aging_priority_round_robin_arbiter_unit;
	import aparb_pkg::*;

	// the fourth func code is unused by the block; it must change nothing
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// cycles to let pass after the last result before touching registers or ending
	localparam int PAUSE       = 40;
	// longest quiet stretch: a sender gap at 70 % idle plus one slow
	// arbitrate plus a register pass, taken many times over
	localparam int QUIET_LIMIT = 2000;
	localparam int BLOCKS      = 10;

	logic                   clk             = 1'b0;
	logic                   arst_n          = 1'b0;
	logic                   start           = 1'b0;
	logic                   busy;
	logic [FUNC_W-1:0]      func            = FUNC_REQUEST;
	logic [REQ_W-1:0]       requester       = '0;
	logic                   link_up         = 1'b0;
	logic [MASK_W-1:0]      nonempty_mask   = '0;
	logic                   send_ok         = 1'b0;
	logic                   store_now_empty = 1'b0;
	logic                   done;
	logic                   granted;
	logic [REQ_W-1:0]       grant_index;
	logic [SCORE_OUT_W-1:0] grant_score;
	logic                   any_pending;
	logic                   cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index       = CFG_ACTIVE;
	logic [CFG_DATA_W-1:0]  cfg_data        = '0;
	logic                   drain_done      = 1'b0;
	int                     fails;

	int               n_sent     = 0;
	int               n_done     = 0;
	int               n_items    = 0;
	int               quiet      = 0;
	int               idle_pct   = 10;
	logic [REQ_W-1:0] last_grant = '0;
	logic [ACT_W-1:0] act_now    = ACTIVE_RST;

	always #2 clk = ~clk;

	aging_priority_round_robin_arbiter_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.requester       (requester),
		.link_up         (link_up),
		.nonempty_mask   (nonempty_mask),
		.send_ok         (send_ok),
		.store_now_empty (store_now_empty),
		.done            (done),
		.granted         (granted),
		.grant_index     (grant_index),
		.grant_score     (grant_score),
		.any_pending     (any_pending),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	aparb_grant_checker u_grant_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.requester       (requester),
		.link_up         (link_up),
		.nonempty_mask   (nonempty_mask),
		.send_ok         (send_ok),
		.store_now_empty (store_now_empty),
		.done            (done),
		.granted         (granted),
		.grant_index     (grant_index),
		.grant_score     (grant_score),
		.any_pending     (any_pending),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.drain_done      (drain_done),
		.fails           (fails)
	);

	// Count command transfers and result strobes at the rising edge, remember
	// the last granted requester so completions can name it, and measure how
	// long nothing has moved on either channel.
	always @(posedge clk) begin
		if (start && !busy)
			n_sent <= n_sent + 1;
		if (done) begin
			n_done <= n_done + 1;
			if (granted)
				last_grant <= grant_index;
		end
		if (!arst_n || (start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	// Watchdog: a hung handshake ends the run.
	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("aging_priority_round_robin_arbiter_unit regression: fail");
		$finish;
	end

	// Present one command from a falling edge and hold it until it transfers.
	// Enter and leave at a falling edge; leave start as it is so the next
	// command can keep it high without a drop in between.
	task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [REQ_W-1:0] r,
			input logic lk, input logic [MASK_W-1:0] ne, input logic ok, input logic em);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start           <= 1'b1;
		func            <= f;
		requester       <= r;
		link_up         <= lk;
		nonempty_mask   <= ne;
		send_ok         <= ok;
		store_now_empty <= em;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		n_items++;
	endtask

	// Drop start, wait for every outstanding result, then hold for extra
	// cycles; return at a falling edge.
	task automatic hold_until_drained(input int extra);
		start <= 1'b0;
		while (n_done != n_sent)
			@(posedge clk);
		repeat (extra)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write all three registers on consecutive cycles; only call while idle.
	task automatic program_cfg(input logic [ACT_W-1:0] act, input logic [MASK_W-1:0] en,
			input logic [PRIO_VEC_W-1:0] pr);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ACTIVE;
		cfg_data  <= CFG_DATA_W'(act);
		@(negedge clk);
		cfg_index <= CFG_ENABLE;
		cfg_data  <= CFG_DATA_W'(en);
		@(negedge clk);
		cfg_index <= CFG_PRIORITY;
		cfg_data  <= pr;
		@(negedge clk);
		cfg_we    <= 1'b0;
		act_now   = act;
	endtask

	// One random episode. Most are well formed: a few requests, an arbitrate
	// with the link up, then a completion for whoever won. The rest bounce
	// the link or send fully random commands, unused code included.
	task automatic run_episode();
		int kind, nreq, lim;
		logic [REQ_W-1:0] r;
		logic [MASK_W-1:0] asked, ne;
		kind  = $urandom_range(99);
		lim   = (act_now == 0) ? 1 : ((act_now > REQUESTERS_DEF) ? REQUESTERS_DEF : act_now);
		asked = '0;
		if (kind < 75) begin
			nreq = $urandom_range(6, 1);
			repeat (nreq) begin
				// mostly in range; now and then a requester past the active count
				if ($urandom_range(9) == 0)
					r = REQ_W'($urandom_range(7));
				else
					r = REQ_W'($urandom_range(lim - 1));
				asked[r] = 1'b1;
				send_cmd(FUNC_REQUEST, r, 1'($urandom), MASK_W'($urandom), 1'($urandom),
					1'($urandom));
			end
			case ($urandom_range(9))
				0, 1, 2, 3, 4: ne = '1;
				5, 6, 7:       ne = asked | MASK_W'($urandom);
				default:       ne = MASK_W'($urandom);
			endcase
			send_cmd(FUNC_ARBITRATE, REQ_W'($urandom), ($urandom_range(19) != 0), ne,
				1'($urandom), 1'($urandom));
			if ($urandom_range(3) != 0) begin
				// wait for the grant so the completion names the winner
				hold_until_drained(0);
				send_cmd(FUNC_COMPLETE, last_grant, 1'($urandom), MASK_W'($urandom),
					($urandom_range(9) != 0), ($urandom_range(9) != 0));
			end
		end else if (kind < 85) begin
			send_cmd(FUNC_ARBITRATE, REQ_W'($urandom), 1'b0, MASK_W'($urandom),
				1'($urandom), 1'($urandom));
			send_cmd(FUNC_ARBITRATE, REQ_W'($urandom), 1'b1, '1, 1'($urandom), 1'($urandom));
		end else begin
			send_cmd(FUNC_W'($urandom_range(3)), REQ_W'($urandom), 1'($urandom),
				MASK_W'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int blk, target;
		logic [ACT_W-1:0] act;
		logic [MASK_W-1:0] en;
		logic [PRIO_VEC_W-1:0] pr;
		logic [REQ_W-1:0] r;

		// Hold reset, then release it once and never again.
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: full ring, mixed priorities with both extremes.
		program_cfg(4'd8, 8'hFF, 64'h01FE_00FF_7F80_FF00);
		// first link-up arbitrate: reconnect requests every requester
		send_cmd(FUNC_ARBITRATE, '0, 1'b1, 8'hFF, 1'b0, 1'b0);
		send_cmd(FUNC_REQUEST, 3'd7, 1'b0, 8'h00, 1'b0, 1'b0);
		send_cmd(FUNC_REQUEST, 3'd0, 1'b1, 8'hFF, 1'b1, 1'b1);
		// every store empty: drop all pending requests
		send_cmd(FUNC_ARBITRATE, '0, 1'b1, 8'h00, 1'b0, 1'b0);
		send_cmd(FUNC_REQUEST, 3'd3, 1'b0, 8'h00, 1'b0, 1'b0);
		send_cmd(FUNC_REQUEST, 3'd5, 1'b0, 8'h00, 1'b0, 1'b0);
		send_cmd(FUNC_ARBITRATE, '0, 1'b1, 8'hFF, 1'b0, 1'b0);
		hold_until_drained(0);
		send_cmd(FUNC_COMPLETE, last_grant, 1'b0, 8'h00, 1'b1, 1'b1);
		// failed transfer, then a store that did not empty
		send_cmd(FUNC_COMPLETE, 3'd5, 1'b0, 8'h00, 1'b0, 1'b1);
		send_cmd(FUNC_COMPLETE, 3'd5, 1'b0, 8'h00, 1'b1, 1'b0);
		send_cmd(FUNC_UNUSED, 3'd7, 1'b1, 8'hFF, 1'b1, 1'b1);
		// link drop, then reconnect against half-empty stores
		send_cmd(FUNC_ARBITRATE, '0, 1'b0, 8'hFF, 1'b0, 1'b0);
		send_cmd(FUNC_ARBITRATE, '0, 1'b1, 8'hAA, 1'b0, 1'b0);
		send_cmd(FUNC_ARBITRATE, '0, 1'b1, 8'h55, 1'b0, 1'b0);
		hold_until_drained(PAUSE);

		// Directed: no requester active, so everything is ignored.
		program_cfg(4'd0, 8'hFF, '1);
		send_cmd(FUNC_REQUEST, 3'd0, 1'b0, 8'h00, 1'b0, 1'b0);
		send_cmd(FUNC_ARBITRATE, 3'd0, 1'b1, 8'hFF, 1'b0, 1'b0);
		send_cmd(FUNC_COMPLETE, 3'd0, 1'b0, 8'h00, 1'b1, 1'b1);
		hold_until_drained(PAUSE);

		// Directed: active count above the ring size, top requester disabled.
		program_cfg(4'd15, 8'h7F, '1);
		send_cmd(FUNC_REQUEST, 3'd7, 1'b0, 8'h00, 1'b0, 1'b0);
		send_cmd(FUNC_ARBITRATE, 3'd0, 1'b1, 8'hFF, 1'b0, 1'b0);
		hold_until_drained(PAUSE);

		// Directed: three active; requests and completions past them drop.
		program_cfg(4'd3, 8'hFF, '0);
		send_cmd(FUNC_REQUEST, 3'd5, 1'b0, 8'h00, 1'b0, 1'b0);
		send_cmd(FUNC_REQUEST, 3'd2, 1'b0, 8'h00, 1'b0, 1'b0);
		send_cmd(FUNC_ARBITRATE, 3'd0, 1'b1, 8'hFF, 1'b0, 1'b0);
		send_cmd(FUNC_COMPLETE, 3'd6, 1'b0, 8'h00, 1'b1, 1'b1);
		hold_until_drained(PAUSE);

		// Random blocks: a new register setting per block; sender idles 10 %
		// in the first four, 70 % in the next three, never in the last three.
		for (blk = 0; blk < BLOCKS; blk++) begin
			idle_pct = (blk < 4) ? 10 : ((blk < 7) ? 70 : 0);
			pr       = {$urandom, $urandom};
			en       = MASK_W'($urandom);
			case (blk)
				0: begin act = 4'd8;  en = '1; end
				1:       act = 4'd1;
				2: begin act = 4'd0;  en = '1; end
				3: begin act = 4'd15; en = '1; pr = '1; end
				4: begin act = 4'd2;  pr = '0; end
				5:       act = 4'd5;
				6: begin act = 4'd8;  en = '1; end
				7: begin act = 4'd12; en = '0; end
				8:       act = 4'd3;
				default: act = ACT_W'($urandom_range(8, 1));
			endcase
			program_cfg(act, en, pr);
			if (blk == 6) begin
				// flood one requester so its count wraps through zero
				r = REQ_W'($urandom_range(7));
				repeat (258)
					send_cmd(FUNC_REQUEST, r, 1'($urandom), MASK_W'($urandom),
						1'($urandom), 1'($urandom));
				send_cmd(FUNC_ARBITRATE, '0, 1'b1, '1, 1'b0, 1'b0);
			end
			// keep the idle-ring block short: it only proves nothing moves
			target = n_items + ((act == 0) ? 30 : 100);
			while (n_items < target)
				run_episode();
			hold_until_drained(PAUSE);
		end

		// Flag anything still owed, let the checker settle, give the verdict.
		drain_done <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (fails == 0)
			$display("aging_priority_round_robin_arbiter_unit regression: pass");
		else
			$display("aging_priority_round_robin_arbiter_unit regression: fail");
		$finish;
	end

endmodule
